// ----- sv/msup_pkg.sv -----
// Shared types, codes and helpers for the motor drive mode supervisor.
`timescale 1ns / 1ps
package msup_pkg;

	// Leaf and composite state codes of the fixed tree
	localparam logic [3:0] ST_ROOT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RUN   = 4'd2;
	localparam logic [3:0] ST_DUTY  = 4'd3;
	localparam logic [3:0] ST_VV    = 4'd4;
	localparam logic [3:0] ST_VF    = 4'd5;
	localparam logic [3:0] ST_CV    = 4'd6;
	localparam logic [3:0] ST_IF    = 4'd7;
	localparam logic [3:0] ST_IFFOC = 4'd8;
	localparam logic [3:0] ST_TRIP  = 4'd9;
	localparam logic [3:0] ST_LIMIT = 4'd10;

	// Event opcodes
	localparam logic [2:0] OP_TRANS  = 3'd0;
	localparam logic [2:0] OP_FAULT  = 3'd1;
	localparam logic [2:0] OP_SPEED  = 3'd2;
	localparam logic [2:0] OP_VECTOR = 3'd3;

	// Control modes
	localparam logic [2:0] MODE_SAFE  = 3'd0;
	localparam logic [2:0] MODE_DUTY  = 3'd1;
	localparam logic [2:0] MODE_VF    = 3'd2;
	localparam logic [2:0] MODE_IF    = 3'd3;
	localparam logic [2:0] MODE_IFFOC = 3'd4;

	// FOC stage write codes
	localparam logic [1:0] STG_NONE   = 2'd0;
	localparam logic [1:0] STG_IDLE   = 2'd1;
	localparam logic [1:0] STG_RESYNC = 2'd2;

	// Reset pulse bits
	localparam logic [8:0] RP_CC  = 9'h001;
	localparam logic [8:0] RP_SC  = 9'h002;
	localparam logic [8:0] RP_OB  = 9'h004;
	localparam logic [8:0] RP_IFG = 9'h008;
	localparam logic [8:0] RP_CVG = 9'h010;
	localparam logic [8:0] RP_VFG = 9'h020;
	localparam logic [8:0] RP_VVG = 9'h040;
	localparam logic [8:0] RP_ACT = 9'h080;
	localparam logic [8:0] RP_EST = 9'h100;
	localparam logic [8:0] RP_FOC = RP_CC | RP_SC | RP_OB | RP_IFG | RP_ACT | RP_EST;

	// Configuration register indexes and reset value
	localparam logic       REG_SPEED_FLOOR   = 1'b0;
	localparam logic [15:0] SPEED_FLOOR_RST  = 16'd1024;

	// One input event
	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  target_state;
		logic [1:0]  field_mask;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic        sensored_handover;
	} ev_t;

	// Architectural state carried from event to event
	typedef struct packed {
		logic [3:0]  leaf;
		logic        pwm;
		logic [2:0]  mode;
		logic [15:0] spd;
		logic [15:0] cnt;
	} arch_t;

	// One result beat
	typedef struct packed {
		logic [3:0]  state_now;
		logic [2:0]  control_mode;
		logic        pwm_on;
		logic [15:0] speed_demand;
		logic [1:0]  stage_write;
		logic [8:0]  reset_pulses;
		logic [3:0]  vector_write;
		logic [15:0] vector_magnitude;
		logic [15:0] vector_angle;
		logic        consumed;
		logic [15:0] unhandled_total;
	} res_t;

	// Working copy of the outputs touched by exit and entry actions
	typedef struct packed {
		logic        pwm;
		logic [2:0]  mode;
		logic [15:0] spd;
		logic [8:0]  pulses;
		logic [1:0]  stg;
	} work_t;

	function automatic logic [3:0] parent_of(input logic [3:0] s);
		logic [3:0] p;
		p = ST_ROOT;
		if (s >= ST_DUTY && s <= ST_IFFOC) p = ST_RUN;
		return p;
	endfunction

endpackage

// ----- sv/msup_cfg.sv -----
// APB-style register port holding the sensorless speed floor.
`timescale 1ns / 1ps
module msup_cfg
	import msup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] speed_floor
);

	logic [15:0] speed_floor_q;
	logic        hit;

	assign hit    = (paddr[2] == REG_SPEED_FLOOR);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_floor_q <= SPEED_FLOOR_RST;
		end else if (psel && penable && pwrite && pready && hit) begin
			speed_floor_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) prdata = {16'd0, speed_floor_q};
	end

	assign speed_floor = speed_floor_q;

endmodule

// ----- sv/msup_step.sv -----
// Event handler: bubbling, exit/entry chain and result forming for one event.
`timescale 1ns / 1ps
module msup_step
	import msup_pkg::*;
(
	input  ev_t         ev,
	input  arch_t       cur,
	input  logic [15:0] speed_floor,
	output arch_t       nxt,
	output res_t        res
);

	function automatic work_t do_exit(input logic [3:0] s, input work_t w_in);
		work_t w;
		w = w_in;
		if (s == ST_IFFOC) begin
			w.pwm    = 1'b0;
			w.mode   = MODE_SAFE;
			w.pulses = w.pulses | RP_FOC;
			w.stg    = STG_IDLE;
		end else if (s == ST_RUN) begin
			w.pwm  = 1'b0;
			w.mode = MODE_SAFE;
		end
		return w;
	endfunction

	function automatic work_t do_entry(input logic [3:0] s, input work_t w_in);
		work_t w;
		w = w_in;
		case (s)
			ST_DUTY: begin
				w.pulses = w.pulses | RP_ACT;
				w.pwm    = 1'b1;
				w.mode   = MODE_DUTY;
			end
			ST_VV, ST_VF: begin
				w.pulses = w.pulses | ((s == ST_VV) ? RP_VVG : RP_VFG) | RP_ACT;
				w.spd    = '0;
				w.pwm    = 1'b1;
				w.mode   = MODE_VF;
			end
			ST_CV, ST_IF: begin
				w.pulses = w.pulses | ((s == ST_CV) ? RP_CVG : RP_IFG) | RP_CC | RP_OB | RP_ACT;
				w.spd    = '0;
				w.pwm    = 1'b1;
				w.mode   = MODE_IF;
			end
			ST_IFFOC: begin
				w.pwm    = 1'b0;
				w.pulses = w.pulses | RP_FOC;
				w.stg    = STG_IDLE;
				w.spd    = '0;
				w.mode   = MODE_SAFE;
			end
			ST_TRIP: begin
				w.pwm  = 1'b0;
				w.mode = MODE_SAFE;
			end
			default: begin
				w.mode = MODE_SAFE;
			end
		endcase
		return w;
	endfunction

	work_t       w;
	logic [3:0]  leaf;
	logic [3:0]  tgt;
	logic [3:0]  lca;
	logic        consumed;
	logic        do_trans;
	logic [3:0]  vwr;
	logic [15:0] vmag;
	logic [15:0] vang;
	logic [16:0] mag;
	logic        run;

	always_comb begin
		w.pwm    = cur.pwm;
		w.mode   = cur.mode;
		w.spd    = cur.spd;
		w.pulses = '0;
		w.stg    = STG_NONE;
		leaf     = cur.leaf;
		consumed = 1'b0;
		do_trans = 1'b0;
		vwr      = '0;
		vmag     = '0;
		vang     = '0;
		tgt      = (ev.op == OP_FAULT) ? ST_TRIP : ev.target_state;
		lca      = ST_ROOT;
		mag      = ev.value_a[15] ? (17'h10000 - {1'b0, ev.value_a}) : {1'b0, ev.value_a};
		run      = (mag >= {1'b0, speed_floor});

		if (ev.op == OP_VECTOR && (cur.leaf == ST_VV || cur.leaf == ST_CV)) begin
			consumed = 1'b1;
			if (ev.field_mask[0]) begin
				vmag = ev.value_a;
				if (cur.leaf == ST_VV) vwr[0] = 1'b1;
				else vwr[2] = 1'b1;
			end
			if (ev.field_mask[1]) begin
				vang = ev.value_b;
				if (cur.leaf == ST_VV) vwr[1] = 1'b1;
				else vwr[3] = 1'b1;
			end
		end else if (ev.op == OP_SPEED && (cur.leaf == ST_VF || cur.leaf == ST_IF)) begin
			consumed = 1'b1;
			if (ev.field_mask[0]) w.spd = ev.value_a;
		end else if (ev.op == OP_SPEED && cur.leaf == ST_IFFOC) begin
			consumed = 1'b1;
			if (ev.field_mask[0]) begin
				w.spd = ev.value_a;
				if (!ev.sensored_handover) begin
					if (run && !cur.pwm) begin
						w.pulses = w.pulses | RP_FOC;
						w.stg    = STG_RESYNC;
						w.pwm    = 1'b1;
						w.mode   = MODE_IFFOC;
					end else if (!run && cur.pwm) begin
						w.pwm    = 1'b0;
						w.mode   = MODE_SAFE;
						w.pulses = w.pulses | RP_FOC;
						w.stg    = STG_IDLE;
					end
				end
			end
		end else if (ev.op == OP_TRANS || ev.op == OP_FAULT) begin
			consumed = 1'b1;
			do_trans = !(tgt >= ST_LIMIT || tgt == ST_ROOT || tgt == ST_RUN) && (tgt != cur.leaf);
		end

		// Exit up to the common ancestor, then enter down to the target
		if (do_trans) begin
			lca = (parent_of(cur.leaf) == parent_of(tgt)) ? parent_of(cur.leaf) : ST_ROOT;
			w = do_exit(cur.leaf, w);
			if (parent_of(cur.leaf) != lca) w = do_exit(parent_of(cur.leaf), w);
			if (parent_of(tgt) != lca) w = do_entry(parent_of(tgt), w);
			w    = do_entry(tgt, w);
			leaf = tgt;
		end

		nxt.leaf = leaf;
		nxt.pwm  = w.pwm;
		nxt.mode = w.mode;
		nxt.spd  = w.spd;
		nxt.cnt  = consumed ? cur.cnt : cur.cnt + 16'd1;

		res.state_now        = leaf;
		res.control_mode     = w.mode;
		res.pwm_on           = w.pwm;
		res.speed_demand     = w.spd;
		res.stage_write      = w.stg;
		res.reset_pulses     = w.pulses;
		res.vector_write     = vwr;
		res.vector_magnitude = vmag;
		res.vector_angle     = vang;
		res.consumed         = consumed;
		res.unhandled_total  = nxt.cnt;
	end

endmodule

// ----- sv/motor_drive_mode_supervisor.sv -----
// Top level of the motor drive mode supervisor: event register, handler, result register.
// Path of an input beat: event register, then result register, then the output port.
// Throughput: one event per cycle while the output is not stalled; the handler closes the
//   exit/entry chain in one pass between the registers and commits the state at that edge.
// Reset (arst_n low, asynchronous): leaf idle, PWM off, safe mode, speed command 0,
//   unhandled count 0, speed floor 1024; both stages empty.
`timescale 1ns / 1ps
module motor_drive_mode_supervisor
	import msup_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// APB-style configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Event input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [3:0]         target_state,
	input  logic [1:0]         field_mask,
	input  logic signed [15:0] value_a,
	input  logic [15:0]        value_b,
	input  logic               sensored_handover,
	// Result output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         state_now,
	output logic [2:0]         control_mode,
	output logic               pwm_on,
	output logic signed [15:0] speed_demand,
	output logic [1:0]         stage_write,
	output logic [8:0]         reset_pulses,
	output logic [3:0]         vector_write,
	output logic signed [15:0] vector_magnitude,
	output logic [15:0]        vector_angle,
	output logic               consumed,
	output logic [15:0]        unhandled_total
);

	logic [15:0] speed_floor;

	// Event register (stage 1), result register (stage 2), committed state
	logic  valid_s1;
	ev_t   ev_s1;
	logic  valid_s2;
	res_t  res_s2;
	arch_t arch_q;

	arch_t arch_nxt;
	res_t  res_nxt;
	logic  in_beat;
	logic  adv;

	msup_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.speed_floor (speed_floor)
	);

	msup_step u_step (
		.ev          (ev_s1),
		.cur         (arch_q),
		.speed_floor (speed_floor),
		.nxt         (arch_nxt),
		.res         (res_nxt)
	);

	// Advance the held event into the result register whenever that register is free
	// or is being drained this cycle; the state commits at the same edge so the next
	// event in stage 1 sees it.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_beat  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			ev_s1.op                <= op;
			ev_s1.target_state      <= target_state;
			ev_s1.field_mask        <= field_mask;
			ev_s1.value_a           <= value_a;
			ev_s1.value_b           <= value_b;
			ev_s1.sensored_handover <= sensored_handover;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q.leaf <= ST_IDLE;
			arch_q.pwm  <= 1'b0;
			arch_q.mode <= MODE_SAFE;
			arch_q.spd  <= '0;
			arch_q.cnt  <= '0;
		end else if (adv) begin
			arch_q <= arch_nxt;
		end
	end

	// Drive the result beat
	assign out_valid        = valid_s2;
	assign state_now        = res_s2.state_now;
	assign control_mode     = res_s2.control_mode;
	assign pwm_on           = res_s2.pwm_on;
	assign speed_demand     = res_s2.speed_demand;
	assign stage_write      = res_s2.stage_write;
	assign reset_pulses     = res_s2.reset_pulses;
	assign vector_write     = res_s2.vector_write;
	assign vector_magnitude = res_s2.vector_magnitude;
	assign vector_angle     = res_s2.vector_angle;
	assign consumed         = res_s2.consumed;
	assign unhandled_total  = res_s2.unhandled_total;

	// PWM enable and a non-safe mode always go together
	a_pwm_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_on == (control_mode != MODE_SAFE)))
		else $error("pwm_on and control_mode disagree");

	// A resync write only comes with the sensorless run starting
	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stage_write == STG_RESYNC) |-> (pwm_on && control_mode == MODE_IFFOC))
		else $error("resync without sensorless start");

	// An unclaimed event causes no side effect
	a_unclaimed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !consumed) |->
			(vector_write == 4'd0 && reset_pulses == 9'd0 && stage_write == STG_NONE))
		else $error("side effect on unconsumed event");

	// Voltage and current vector writes never mix in one event
	a_vec_side: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && vector_write[1:0] != 2'd0) |-> (vector_write[3:2] == 2'd0))
		else $error("voltage and current vector written together");

endmodule

// ----- tb/sv/msup_checker.sv -----
// Result checker for the motor drive mode supervisor: tracks both channels and the register port.
`timescale 1ns / 1ps
module msup_checker
	import msup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  op,
	input  logic [3:0]  target_state,
	input  logic [1:0]  field_mask,
	input  logic [15:0] value_a,
	input  logic [15:0] value_b,
	input  logic        sensored_handover,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  state_now,
	input  logic [2:0]  control_mode,
	input  logic        pwm_on,
	input  logic [15:0] speed_demand,
	input  logic [1:0]  stage_write,
	input  logic [8:0]  reset_pulses,
	input  logic [3:0]  vector_write,
	input  logic [15:0] vector_magnitude,
	input  logic [15:0] vector_angle,
	input  logic        consumed,
	input  logic [15:0] unhandled_total,
	output int          mismatches,
	output int          outstanding
);

	localparam logic [3:0] VW_VMAG = 4'b0001;
	localparam logic [3:0] VW_VANG = 4'b0010;
	localparam logic [3:0] VW_IMAG = 4'b0100;
	localparam logic [3:0] VW_IANG = 4'b1000;
	localparam logic [2:0] FLOOR_ADDR = {REG_SPEED_FLOOR, 2'b00};

	// Supervisor state as this checker sees it
	logic [3:0]  leaf_q;
	logic        pwm_q;
	logic [2:0]  mode_q;
	logic [15:0] spd_q;
	logic [15:0] unhandled_q;
	logic [15:0] floor_q;
	// Pulses and stage write gathered while one event is handled
	logic [8:0]  pulse_acc;
	logic [1:0]  stage_acc;

	res_t pending_results[$];
	int   err_tally = 0;

	task automatic log_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_tally++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic logic [3:0] branch_of(input logic [3:0] s);
		case (s)
			ST_DUTY, ST_VV, ST_VF, ST_CV, ST_IF, ST_IFFOC: return ST_RUN;
			default: return ST_ROOT;
		endcase
	endfunction

	task automatic foc_clear();
		pulse_acc |= RP_FOC;
		stage_acc = STG_IDLE;
	endtask

	task automatic leave_state(input logic [3:0] s);
		if (s == ST_IFFOC) begin
			pwm_q = 1'b0;
			mode_q = MODE_SAFE;
			foc_clear();
		end else if (s == ST_RUN) begin
			pwm_q = 1'b0;
			mode_q = MODE_SAFE;
		end
	endtask

	task automatic enter_state(input logic [3:0] s);
		case (s)
			ST_DUTY: begin
				pulse_acc |= RP_ACT;
				pwm_q = 1'b1;
				mode_q = MODE_DUTY;
			end
			ST_VV, ST_VF: begin
				pulse_acc |= ((s == ST_VV) ? RP_VVG : RP_VFG) | RP_ACT;
				spd_q = '0;
				pwm_q = 1'b1;
				mode_q = MODE_VF;
			end
			ST_CV, ST_IF: begin
				pulse_acc |= ((s == ST_CV) ? RP_CVG : RP_IFG) | RP_CC | RP_OB | RP_ACT;
				spd_q = '0;
				pwm_q = 1'b1;
				mode_q = MODE_IF;
			end
			ST_IFFOC: begin
				pwm_q = 1'b0;
				foc_clear();
				spd_q = '0;
				mode_q = MODE_SAFE;
			end
			ST_TRIP: begin
				pwm_q = 1'b0;
				mode_q = MODE_SAFE;
			end
			default: mode_q = MODE_SAFE;
		endcase
	endtask

	// Exit up to the common ancestor, then enter down to the target
	task automatic walk_to(input logic [3:0] target);
		logic [3:0] from;
		logic [3:0] common;
		from = leaf_q;
		if (target >= ST_LIMIT || target == ST_ROOT || target == ST_RUN || target == from)
			return;
		common = (branch_of(from) == branch_of(target)) ? branch_of(from) : ST_ROOT;
		leave_state(from);
		if (branch_of(from) != common) leave_state(branch_of(from));
		if (branch_of(target) != common) enter_state(branch_of(target));
		enter_state(target);
		leaf_q = target;
	endtask

	task automatic predict_event(input ev_t e, output res_t r);
		logic [16:0] demand_mag;
		logic        runs;
		r = '0;
		pulse_acc = '0;
		stage_acc = STG_NONE;
		if (e.op == OP_VECTOR && (leaf_q == ST_VV || leaf_q == ST_CV)) begin
			// voltage pair in VV, current pair in CV
			if (e.field_mask[0]) begin
				r.vector_write |= (leaf_q == ST_VV) ? VW_VMAG : VW_IMAG;
				r.vector_magnitude = e.value_a;
			end
			if (e.field_mask[1]) begin
				r.vector_write |= (leaf_q == ST_VV) ? VW_VANG : VW_IANG;
				r.vector_angle = e.value_b;
			end
			r.consumed = 1'b1;
		end else if (e.op == OP_SPEED && (leaf_q == ST_VF || leaf_q == ST_IF)) begin
			if (e.field_mask[0]) spd_q = e.value_a;
			r.consumed = 1'b1;
		end else if (e.op == OP_SPEED && leaf_q == ST_IFFOC) begin
			r.consumed = 1'b1;
			if (e.field_mask[0]) begin
				spd_q = e.value_a;
				if (!e.sensored_handover) begin
					demand_mag = e.value_a[15] ? (17'h10000 - {1'b0, e.value_a})
						: {1'b0, e.value_a};
					runs = demand_mag >= {1'b0, floor_q};
					if (runs && !pwm_q) begin
						foc_clear();
						stage_acc = STG_RESYNC;
						pwm_q = 1'b1;
						mode_q = MODE_IFFOC;
					end else if (!runs && pwm_q) begin
						pwm_q = 1'b0;
						mode_q = MODE_SAFE;
						foc_clear();
					end
				end
			end
		end else if (e.op == OP_TRANS) begin
			walk_to(e.target_state);
			r.consumed = 1'b1;
		end else if (e.op == OP_FAULT) begin
			walk_to(ST_TRIP);
			r.consumed = 1'b1;
		end
		if (!r.consumed) unhandled_q++;
		r.state_now = leaf_q;
		r.control_mode = mode_q;
		r.pwm_on = pwm_q;
		r.speed_demand = spd_q;
		r.stage_write = stage_acc;
		r.reset_pulses = pulse_acc;
		r.unhandled_total = unhandled_q;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ev_t  seen_ev;
		res_t want;
		if (!arst_n) begin
			leaf_q = ST_IDLE;
			pwm_q = 1'b0;
			mode_q = MODE_SAFE;
			spd_q = '0;
			unhandled_q = '0;
			floor_q = SPEED_FLOOR_RST;
			pending_results.delete();
			outstanding <= 0;
			mismatches <= err_tally;
		end else begin
			if (psel && penable && pwrite && pready && paddr == FLOOR_ADDR)
				floor_q = pwdata[15:0];
			if (in_valid && !in_stall) begin
				seen_ev.op = op;
				seen_ev.target_state = target_state;
				seen_ev.field_mask = field_mask;
				seen_ev.value_a = value_a;
				seen_ev.value_b = value_b;
				seen_ev.sensored_handover = sensored_handover;
				predict_event(seen_ev, want);
				pending_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					log_mismatch("result beat with nothing expected");
				end else begin
					want = pending_results.pop_front();
					compare_field("state_now", state_now, want.state_now);
					compare_field("control_mode", control_mode, want.control_mode);
					compare_field("pwm_on", pwm_on, want.pwm_on);
					compare_field("speed_demand", speed_demand, want.speed_demand);
					compare_field("stage_write", stage_write, want.stage_write);
					compare_field("reset_pulses", reset_pulses, want.reset_pulses);
					compare_field("vector_write", vector_write, want.vector_write);
					compare_field("vector_magnitude", vector_magnitude,
						want.vector_magnitude);
					compare_field("vector_angle", vector_angle, want.vector_angle);
					compare_field("consumed", consumed, want.consumed);
					compare_field("unhandled_total", unhandled_total, want.unhandled_total);
				end
			end
			outstanding <= pending_results.size();
			mismatches <= err_tally;
		end
	end

endmodule

// ----- tb/sv/motor_drive_mode_supervisor_test.sv -----
// Testbench top for the motor drive mode supervisor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module motor_drive_mode_supervisor_test;
	import msup_pkg::*;

	// Codes the package leaves unnamed: set duty is never handled, nor is anything above it
	localparam logic [2:0] OP_DUTY    = 3'd4;
	localparam logic [2:0] OP_LAST    = 3'd7;
	localparam logic [3:0] ST_BAD_TOP = 4'd15;
	localparam logic [2:0] FLOOR_ADDR = {REG_SPEED_FLOOR, 2'b00};
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_CYCLES  = 60;
	localparam int QUIET_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [3:0]  target_state = '0;
	logic [1:0]  field_mask = '0;
	logic [15:0] value_a = '0;
	logic [15:0] value_b = '0;
	logic        sensored_handover = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  state_now;
	logic [2:0]  control_mode;
	logic        pwm_on;
	logic [15:0] speed_demand;
	logic [1:0]  stage_write;
	logic [8:0]  reset_pulses;
	logic [3:0]  vector_write;
	logic [15:0] vector_magnitude;
	logic [15:0] vector_angle;
	logic        consumed;
	logic [15:0] unhandled_total;
	int          mismatches;
	int          outstanding;

	// Coordination between the sender and the receiver processes
	bit calm = 1'b0;          // last part of the run: no idling on either side
	bit hold_request = 1'b0;  // ask the receiver for one long hold-off
	bit holding = 1'b0;       // receiver is in that hold-off; sender keeps pushing
	logic [15:0] floor_now = SPEED_FLOOR_RST;

	motor_drive_mode_supervisor DUT (.*);

	msup_checker u_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Offer one event beat, after an optional random gap, and hold it until it is taken
	task automatic offer(input logic [2:0] o, input logic [3:0] tgt, input logic [1:0] msk,
			input logic [15:0] va, input logic [15:0] vb, input logic ho);
		if (!calm && !holding && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		target_state <= tgt;
		field_mask <= msk;
		value_a <= va;
		value_b <= vb;
		sensored_handover <= ho;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop the input and wait until every expected result beat has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands at the edge where pready is seen high
	task automatic write_floor(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= FLOOR_ADDR;
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		floor_now = value;
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none once calm
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				holding = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end else if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [15:0] phase_floor [5];
		logic [2:0]  o;
		logic [3:0]  tgt;
		logic [1:0]  msk;
		logic [15:0] va;
		int          pick;
		int          near;

		// Floors per phase: zero, the top of the range, one, the reset value, random
		phase_floor[0] = 16'd0;
		phase_floor[1] = 16'd32768;
		phase_floor[2] = 16'd1;
		phase_floor[3] = SPEED_FLOOR_RST;
		phase_floor[4] = 16'($urandom_range(0, 32768));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk from idle with the reset floor
		offer(OP_DUTY, ST_IDLE, 2'b11, 16'h1234, 16'h4321, 1'b0);   // never handled
		offer(OP_LAST, ST_TRIP, 2'b00, 16'h0000, 16'h0000, 1'b1);   // never handled
		offer(OP_TRANS, ST_ROOT, 2'b00, 16'h0000, 16'h0000, 1'b0);  // bad target
		offer(OP_TRANS, ST_RUN, 2'b00, 16'h0000, 16'h0000, 1'b0);   // bad target
		offer(OP_TRANS, ST_BAD_TOP, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_TRANS, ST_IDLE, 2'b00, 16'h0000, 16'h0000, 1'b0);  // already there
		offer(OP_TRANS, ST_DUTY, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_VECTOR, ST_IDLE, 2'b11, 16'h0100, 16'h0200, 1'b0); // no vector handler
		offer(OP_TRANS, ST_VV, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_VECTOR, ST_ROOT, 2'b11, 16'h8000, 16'hFFFF, 1'b0);
		offer(OP_VECTOR, ST_ROOT, 2'b00, 16'h7FFF, 16'h0001, 1'b0); // nothing written
		offer(OP_TRANS, ST_CV, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_VECTOR, ST_ROOT, 2'b01, 16'h7FFF, 16'hAAAA, 1'b0);
		offer(OP_TRANS, ST_VF, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_SPEED, ST_ROOT, 2'b10, 16'h5555, 16'h0000, 1'b0);  // value missing
		offer(OP_SPEED, ST_ROOT, 2'b01, 16'h8000, 16'h0000, 1'b0);
		offer(OP_TRANS, ST_IF, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_SPEED, ST_ROOT, 2'b01, 16'h7FFF, 16'h0000, 1'b0);
		offer(OP_TRANS, ST_IFFOC, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_SPEED, ST_ROOT, 2'b01, 16'h8000, 16'h0000, 1'b0);  // starts the run
		offer(OP_SPEED, ST_ROOT, 2'b11, 16'h0000, 16'h0000, 1'b0);  // stops it
		offer(OP_SPEED, ST_ROOT, 2'b01, 16'd5000, 16'h0000, 1'b1);  // sensored: store only
		offer(OP_FAULT, ST_IDLE, 2'b00, 16'h0000, 16'h0000, 1'b0);
		offer(OP_FAULT, ST_IDLE, 2'b00, 16'h0000, 16'h0000, 1'b0);  // already faulted
		offer(OP_TRANS, ST_IDLE, 2'b00, 16'h0000, 16'h0000, 1'b0);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			// Register writes only while the block is drained
			write_floor(phase_floor[phase]);
			if (phase == 4) calm = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Fill the block once: long receiver hold-off while the sender keeps going
				if (phase == 1 && n == 40) hold_request = 1'b1;

				// Leaf targets dominate so speed and vector events land in live leaves
				case ($urandom_range(0, 9))
					0: tgt = ST_IDLE;
					1: tgt = ST_DUTY;
					2: tgt = ST_VV;
					3: tgt = ST_VF;
					4: tgt = ST_CV;
					5: tgt = ST_IF;
					6, 7: tgt = ST_IFFOC;
					8: tgt = ST_TRIP;
					default: tgt = 4'($urandom_range(0, 15));
				endcase

				pick = $urandom_range(0, 99);
				if (pick < 30) o = OP_TRANS;
				else if (pick < 36) o = OP_FAULT;
				else if (pick < 66) o = OP_SPEED;
				else if (pick < 86) o = OP_VECTOR;
				else o = 3'($urandom_range(OP_DUTY, OP_LAST));

				msk = 2'($urandom_range(0, 3));
				if (o == OP_SPEED && $urandom_range(0, 9) != 0) msk[0] = 1'b1;

				// Speed demands cluster around the floor, either sign, plus the extremes
				case ($urandom_range(0, 4))
					0, 1: begin
						near = int'(floor_now) + int'($urandom_range(0, 4)) - 2;
						if ($urandom_range(0, 1) == 1) near = -near;
						va = near[15:0];
					end
					2: va = 16'h8000;
					3: va = 16'h7FFF;
					default: va = 16'($urandom);
				endcase

				offer(o, tgt, msk, va, 16'($urandom), $urandom_range(0, 3) == 0);
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
